// ----- rtl/udec_pkg.sv -----
// ----------------------------------------------------------------------------
// udec_pkg: shared types for the unicode stream decoder
// Encoding and status codes, the operation format that travels from the
// detection front to the decode back, and the result format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package udec_pkg;

  typedef enum logic [2:0] {
    ENC_UCS4BE  = 3'd0,
    ENC_UCS4LE  = 3'd1,
    ENC_UTF16BE = 3'd2,
    ENC_UTF16LE = 3'd3,
    ENC_UTF8    = 3'd4,
    ENC_EBCDIC  = 3'd5,
    ENC_LATIN1  = 3'd6
  } enc_t;

  typedef enum logic [1:0] {
    ST_CHAR   = 2'd0,
    ST_END    = 2'd1,
    ST_BADSUR = 2'd2,
    ST_UNSUP  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_DECODE = 2'd0,
    OP_UNSUP  = 2'd1,
    OP_END    = 2'd2
  } op_kind_t;

  // eoi marks the last operation that one input item produces
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    enc_t       enc;
    logic       eoi;
  } op_t;

  typedef struct packed {
    logic [31:0] code_point;
    status_t     status;
    enc_t        enc;
    logic        run_last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/udec_byte_if.sv -----
// ----------------------------------------------------------------------------
// udec_byte_if: input byte channel
// Valid/ready channel that carries one raw stream byte per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface udec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_last;

  modport source (output valid, output data_byte, output stream_last, input ready);
  modport sink   (input valid, input data_byte, input stream_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/udec_result_if.sv -----
// ----------------------------------------------------------------------------
// udec_result_if: result channel
// Valid/ready channel that carries one decoded result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface udec_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic [1:0]  status;
  logic [2:0]  detected_encoding;
  logic        run_last;

  modport source (output valid, output code_point, output status,
                  output detected_encoding, output run_last, input ready);
  modport sink   (input valid, input code_point, input status,
                  input detected_encoding, input run_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/unicode_stream_decoder.sv -----
// An operation passes the queue slot, then its result the held-result and output registers;
//   a result that is not the last of its byte waits for a newer result or its byte's last operation.
// Throughput: one byte per cycle while the queue has room; a byte that makes several operations
//   (replayed bytes, end or unsupported marker, at most five) holds off input until all are issued.
// Reset: synchronous, active high; clears phase, counters, queue and output valid,
//   but not the detection byte buffer.
// ----------------------------------------------------------------------------
// unicode_stream_decoder: byte stream to code point decoder
// Detection front, operation queue and decode back joined on valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unicode_stream_decoder import udec_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  udec_byte_if.sink     bytes,
  udec_result_if.source results
);

  logic    op_valid;
  op_t     op;
  logic    op_ready;
  logic    q_valid;
  op_t     q_op;
  logic    q_ready;
  logic    res_valid;
  result_t res;

  udec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_data  (bytes.data_byte),
    .in_last  (bytes.stream_last),
    .in_ready (bytes.ready),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready)
  );

  udec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (op_valid),
    .push_op    (op),
    .push_ready (op_ready),
    .pop_valid  (q_valid),
    .pop_op     (q_op),
    .pop_ready  (q_ready)
  );

  udec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op        (q_op),
    .op_ready  (q_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (results.ready)
  );

  assign results.valid             = res_valid;
  assign results.code_point        = res.code_point;
  assign results.status            = res.status;
  assign results.detected_encoding = res.enc;
  assign results.run_last          = res.run_last;

endmodule

`default_nettype wire

// ----- rtl/udec_front.sv -----
// ----------------------------------------------------------------------------
// udec_front: encoding detection and operation issue
// Buffers the first bytes of a stream, picks the encoding from byte-order
// marks and declaration patterns, issues decode operations for the bytes past
// the mark (replaying buffered bytes) and issues end and unsupported markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udec_front import udec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       in_ready,
  output logic       op_valid,
  output op_t        op,
  input  logic       op_ready
);

  localparam logic [15:0] BOM16_BE     = 16'hFEFF;
  localparam logic [15:0] BOM16_LE     = 16'hFFFE;
  localparam logic [23:0] BOM8         = 24'hEFBBBF;
  localparam logic [31:0] PAT_UCS4_LE  = 32'hFFFE_0000;
  localparam logic [31:0] PAT_UCS4_BE  = 32'h0000_FEFF;
  localparam logic [31:0] PAT_XML16_BE = 32'h003C_003F;
  localparam logic [31:0] PAT_XML16_LE = 32'h3C00_3F00;
  localparam logic [31:0] PAT_XML8     = 32'h3C3F_786D;
  localparam logic [31:0] PAT_XML_EBC  = 32'h4C6F_A794;

  typedef enum logic [1:0] {F_DETECT, F_RUN, F_HALT} fphase_t;

  // pending operations of one item: replay bytes[idx..cnt-1], then markers
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      idx;
    logic [2:0]      cnt;
    logic            unsup;
    logic            endf;
    enc_t            enc;
  } work_t;

  fphase_t         phase;
  logic [3:0][7:0] det_bytes;
  logic [2:0]      det_count;
  enc_t            enc_sel;
  work_t           work;
  logic            busy;

  logic [3:0][7:0] d_next;
  logic [2:0]      c_next;
  logic [31:0]     word4;
  logic            hit;
  enc_t            hit_enc;
  logic [2:0]      hit_skip;
  work_t           inc;
  work_t           cur;
  work_t           rem;
  logic            in_fire;
  logic            has_dec;
  logic            advance;
  logic            rem_busy;

  assign in_ready = !busy && op_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    d_next = det_bytes;
    d_next[det_count[1:0]] = in_data;
    c_next = det_count + 3'd1;
    word4  = {d_next[0], d_next[1], d_next[2], d_next[3]};

    hit      = 1'b0;
    hit_enc  = enc_sel;
    hit_skip = 3'd0;
    if (c_next == 3'd2 && word4[31:16] == BOM16_BE) begin
      hit = 1'b1; hit_enc = ENC_UTF16BE; hit_skip = 3'd2;
    end else if (c_next == 3'd3 && word4[31:8] == BOM8) begin
      hit = 1'b1; hit_enc = ENC_UTF8; hit_skip = 3'd3;
    end else if (c_next == 3'd4) begin
      hit = 1'b1;
      if (word4 == PAT_UCS4_LE) begin
        hit_enc = ENC_UCS4LE; hit_skip = 3'd4;
      end else if (word4[31:16] == BOM16_LE) begin
        hit_enc = ENC_UTF16LE; hit_skip = 3'd2;
      end else if (word4 == PAT_UCS4_BE) begin
        hit_enc = ENC_UCS4BE; hit_skip = 3'd4;
      end else if (word4 == PAT_XML16_BE) begin
        hit_enc = ENC_UTF16BE; hit_skip = 3'd0;
      end else if (word4 == PAT_XML16_LE) begin
        hit_enc = ENC_UTF16LE; hit_skip = 3'd0;
      end else if (word4 == PAT_XML8) begin
        hit_enc = ENC_UTF8; hit_skip = 3'd4;
      end else if (word4 == PAT_XML_EBC) begin
        hit_enc = ENC_EBCDIC; hit_skip = 3'd4;
      end else begin
        hit_enc = ENC_LATIN1; hit_skip = 3'd0;
      end
    end else if (in_last) begin
      // short stream: a little-endian mark still wins
      hit = 1'b1;
      if (c_next >= 3'd2 && word4[31:16] == BOM16_LE) begin
        hit_enc = ENC_UTF16LE; hit_skip = 3'd2;
      end else begin
        hit_enc = ENC_LATIN1; hit_skip = 3'd0;
      end
    end

    inc       = '0;
    inc.enc   = enc_sel;
    inc.endf  = in_last;
    case (phase)
      F_DETECT: begin
        inc.bytes = d_next;
        if (hit) begin
          inc.enc = hit_enc;
          if (hit_enc == ENC_UTF8 || hit_enc == ENC_EBCDIC) begin
            inc.unsup = 1'b1;
          end else begin
            inc.idx = hit_skip;
            inc.cnt = c_next;
          end
        end
      end
      F_RUN: begin
        inc.bytes[0] = in_data;
        inc.cnt      = 3'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cur     = busy ? work : inc;
    has_dec = cur.idx < cur.cnt;
    advance = busy ? op_ready : in_fire;

    op.data = cur.bytes[cur.idx[1:0]];
    op.enc  = cur.enc;
    rem     = cur;
    if (has_dec) begin
      op.kind = OP_DECODE;
      op.eoi  = (cur.idx + 3'd1 == cur.cnt) && !cur.unsup && !cur.endf;
      rem.idx = cur.idx + 3'd1;
    end else if (cur.unsup) begin
      op.kind   = OP_UNSUP;
      op.eoi    = !cur.endf;
      rem.unsup = 1'b0;
    end else begin
      op.kind  = OP_END;
      op.eoi   = 1'b1;
      rem.endf = 1'b0;
    end
    op_valid = (busy || in_fire) && (has_dec || cur.unsup || cur.endf);
    rem_busy = (rem.idx < rem.cnt) || rem.unsup || rem.endf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= F_DETECT;
      det_count <= 3'd0;
      enc_sel   <= ENC_LATIN1;
      busy      <= 1'b0;
    end else begin
      if (advance) begin
        work <= rem;
        busy <= rem_busy;
      end
      if (in_fire) begin
        if (phase == F_DETECT) begin
          det_bytes <= d_next;
        end
        if (in_last) begin
          // restart detection for the next stream
          phase     <= F_DETECT;
          det_count <= 3'd0;
          enc_sel   <= ENC_LATIN1;
        end else if (phase == F_DETECT) begin
          det_count <= c_next;
          if (hit) begin
            enc_sel <= hit_enc;
            phase   <= (hit_enc == ENC_UTF8 || hit_enc == ENC_EBCDIC) ? F_HALT : F_RUN;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/udec_queue.sv -----
// ----------------------------------------------------------------------------
// udec_queue: operation queue
// Small first-in first-out buffer that decouples detection from decoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udec_queue import udec_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  op_t  push_op,
  output logic push_ready,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  op_t           slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign push_ready = fill != FW'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_op     = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/udec_back.sv -----
// ----------------------------------------------------------------------------
// udec_back: unit assembly and result issue
// Assembles code units, pairs UTF-16 surrogates, and holds each result one
// stage so that the last result of an input item carries run_last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udec_back import udec_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  input  op_t     op,
  output logic    op_ready,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);

  localparam logic [15:0] SUR_HI_MIN = 16'hD800;
  localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
  localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;

  logic [31:0] unit;
  logic [1:0]  ucnt;
  logic [15:0] high_sur;
  logic        sur_pending;
  logic        stopped;

  logic [31:0] unit_next;
  logic [1:0]  ucnt_next;
  logic [15:0] high_sur_next;
  logic        sur_pending_next;
  logic        stopped_next;

  logic [31:0] asm32;
  logic [15:0] asm16;
  logic [15:0] u16;
  logic        r_valid;
  result_t     r;

  logic        h_valid;
  logic        h_final;
  result_t     h_res;
  logic        o_free;
  logic        move;
  logic        fire;

  always_comb begin
    asm32 = {unit[23:0], op.data};
    asm16 = {unit[7:0], op.data};
    u16   = (op.enc == ENC_UTF16LE) ? {asm16[7:0], asm16[15:8]} : asm16;

    unit_next        = unit;
    ucnt_next        = ucnt;
    high_sur_next    = high_sur;
    sur_pending_next = sur_pending;
    stopped_next     = stopped;
    r_valid          = 1'b0;
    r                = '0;
    r.enc            = op.enc;
    r.status         = ST_CHAR;

    case (op.kind)
      OP_DECODE: begin
        if (!stopped) begin
          case (op.enc)
            ENC_LATIN1: begin
              r_valid      = 1'b1;
              r.code_point = {24'd0, op.data};
            end
            ENC_UCS4BE, ENC_UCS4LE: begin
              if (ucnt == 2'd3) begin
                r_valid      = 1'b1;
                r.code_point = (op.enc == ENC_UCS4LE) ?
                               {asm32[7:0], asm32[15:8], asm32[23:16], asm32[31:24]} :
                               asm32;
                unit_next    = '0;
                ucnt_next    = 2'd0;
              end else begin
                unit_next = asm32;
                ucnt_next = ucnt + 2'd1;
              end
            end
            ENC_UTF16BE, ENC_UTF16LE: begin
              if (ucnt == 2'd1) begin
                unit_next = '0;
                ucnt_next = 2'd0;
                if (sur_pending) begin
                  r_valid = 1'b1;
                  if (u16 >= SUR_LO_MIN && u16 <= SUR_LO_MAX) begin
                    r.code_point     = SUPP_BASE + {12'd0, high_sur[9:0], u16[9:0]};
                    sur_pending_next = 1'b0;
                    high_sur_next    = '0;
                  end else begin
                    // broken pair: report and stop the stream
                    r.status     = ST_BADSUR;
                    stopped_next = 1'b1;
                  end
                end else if (u16 >= SUR_HI_MIN && u16 <= SUR_HI_MAX) begin
                  high_sur_next    = u16;
                  sur_pending_next = 1'b1;
                end else begin
                  r_valid      = 1'b1;
                  r.code_point = {16'd0, u16};
                end
              end else begin
                unit_next = {16'd0, asm16};
                ucnt_next = ucnt + 2'd1;
              end
            end
            default: ;
          endcase
        end
      end
      OP_UNSUP: begin
        r_valid      = 1'b1;
        r.status     = ST_UNSUP;
        stopped_next = 1'b1;
      end
      OP_END: begin
        r_valid          = 1'b1;
        r.status         = ST_END;
        unit_next        = '0;
        ucnt_next        = 2'd0;
        high_sur_next    = '0;
        sur_pending_next = 1'b0;
        stopped_next     = 1'b0;
      end
      default: ;
    endcase
  end

  // once the output is free, the held result leaves when its item is known finished or a newer result arrives
  assign o_free   = !res_valid || res_ready;
  assign move     = o_free && h_valid && (h_final || (op_valid && r_valid));
  assign fire     = op_valid && (!(h_valid && (h_final || r_valid)) || o_free);
  assign op_ready = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit        <= '0;
      ucnt        <= 2'd0;
      high_sur    <= '0;
      sur_pending <= 1'b0;
      stopped     <= 1'b0;
      h_valid     <= 1'b0;
      h_final     <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (fire) begin
        unit        <= unit_next;
        ucnt        <= ucnt_next;
        high_sur    <= high_sur_next;
        sur_pending <= sur_pending_next;
        stopped     <= stopped_next;
      end
      if (move) begin
        res_valid <= 1'b1;
        res       <= {h_res.code_point, h_res.status, h_res.enc, h_final};
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (fire && r_valid) begin
        h_valid <= 1'b1;
        h_final <= op.eoi;
        h_res   <= r;
      end else if (fire && h_valid && !move) begin
        h_final <= h_final || op.eoi;
      end else if (move) begin
        h_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/udec_checker.sv -----
// ----------------------------------------------------------------------------
// udec_checker: result port checks
// Watches the result channel of the decoder; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module udec_checker import udec_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] code_point,
  input logic [1:0]  status,
  input logic [2:0]  detected_encoding,
  input logic        run_last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(code_point) && $stable(status) &&
                                $stable(detected_encoding) && $stable(run_last))
    else $error("result payload changed while stalled");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_CHAR |-> code_point == 32'd0)
    else $error("marker result carries a nonzero code point");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_END |-> run_last)
    else $error("end of stream is not the last result of its item");

  a_utf16_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_CHAR &&
    (detected_encoding == ENC_UTF16BE || detected_encoding == ENC_UTF16LE)
    |-> code_point <= 32'h0010_FFFF)
    else $error("UTF-16 character out of range");

endmodule

bind unicode_stream_decoder udec_checker u_udec_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (results.valid),
  .out_ready         (results.ready),
  .code_point        (results.code_point),
  .status            (results.status),
  .detected_encoding (results.detected_encoding),
  .run_last          (results.run_last)
);

`default_nettype wire

// ----- tb/tb_unicode_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unicode_stream_decoder: self-checking bench for the unicode stream decoder
// Feeds byte streams that begin with every byte-order mark and declaration
// prefix the detector knows, plus Latin-1 and noise streams, under random
// idling and stalls on both channels. A cycle-free model of the decoder or the
// directed table predicts every result, and each result item is compared in order.
// ----------------------------------------------------------------------------

module tb_unicode_stream_decoder;
  import udec_pkg::*;

  typedef enum logic [1:0] {PH_SNIFF, PH_DECODE, PH_HALT} dec_phase_e;

  typedef enum int {
    SK_BOM16BE, SK_BOM16LE, SK_BOM32LE, SK_BOM32BE, SK_XML16BE, SK_XML16LE,
    SK_XML8, SK_BOM8, SK_EBCDIC, SK_LATIN1, SK_NOISE
  } stream_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    logic        typed;
    logic [31:0] cp;
    status_t     st;
    enc_t        enc;
  } dir_row_t;

  localparam logic [31:0] MARK_UCS4LE  = 32'hFFFE0000;
  localparam logic [31:0] MARK_UCS4BE  = 32'h0000FEFF;
  localparam logic [31:0] DECL_UTF16BE = 32'h003C003F;
  localparam logic [31:0] DECL_UTF16LE = 32'h3C003F00;
  localparam logic [31:0] DECL_UTF8    = 32'h3C3F786D;
  localparam logic [31:0] DECL_EBCDIC  = 32'h4C6FA794;
  localparam logic [15:0] MARK_UTF16BE = 16'hFEFF;
  localparam logic [15:0] MARK_UTF16LE = 16'hFFFE;
  localparam logic [23:0] MARK_UTF8    = 24'hEFBBBF;

  localparam int DIR_N      = 29;
  localparam int RAND_ITEMS = 200;
  localparam int HOLD_AT    = 90;
  localparam int HOLD_LEN   = 80;
  localparam int CALM_FROM  = 140;
  localparam int CALM_TO    = 190;
  localparam int PAUSE_AT   = 8;

  // Directed streams: UTF-8 mark, UTF-16 BE with a lone low surrogate, a pair and
  // a bad pair, UCS-4 LE with an all-ones and a truncated unit, short FF FE stream, short Latin-1.
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'hEF, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hBB, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hBF, 1'b0, 1'b1, 32'h0, ST_UNSUP, ENC_UTF8},
    '{8'h00, 1'b1, 1'b1, 32'h0, ST_END, ENC_UTF8},
    '{8'hFE, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hFF, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hDC, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'h01, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hD8, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'h3D, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hDE, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'h00, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hDB, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hFF, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'h00, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'h41, 1'b1, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hFF, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hFE, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'h00, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'h00, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hFF, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hFF, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hFF, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hFF, 1'b0, 1'b1, 32'hFFFFFFFF, ST_CHAR, ENC_UCS4LE},
    '{8'h00, 1'b1, 1'b1, 32'h0, ST_END, ENC_UCS4LE},
    '{8'hFF, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'hFE, 1'b0, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1},
    '{8'h5A, 1'b1, 1'b1, 32'h0, ST_END, ENC_UTF16LE},
    '{8'h41, 1'b1, 1'b0, 32'h0, ST_CHAR, ENC_LATIN1}
  };

  logic clk;
  logic rst;

  udec_byte_if   bytes_if();
  udec_result_if res_if();

  unicode_stream_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_if),
    .results (res_if)
  );

  // decoder model state
  logic [7:0]  sn_buf [4];
  int          sn_cnt;
  dec_phase_e  dec_phase;
  enc_t        cur_enc;
  logic [31:0] unit_acc;
  int          unit_cnt;
  logic [15:0] hi_sur;
  logic        sur_pend;

  result_t    step_res [$];
  result_t    expected_q [$];
  byte_item_t stim_q [$];

  int items_sent;
  int streams_sent;
  int results_seen;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results still outstanding", expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void reset_model();
    sn_cnt    = 0;
    dec_phase = PH_SNIFF;
    cur_enc   = ENC_LATIN1;
    unit_acc  = '0;
    unit_cnt  = 0;
    hi_sur    = '0;
    sur_pend  = 1'b0;
  endfunction

  function automatic void add_result(logic [31:0] cp, status_t st);
    result_t r;
    if (step_res.size() >= 5) return;
    r.code_point = cp;
    r.status     = st;
    r.enc        = cur_enc;
    r.run_last   = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [31:0] w;
    logic [15:0] u;
    if (dec_phase != PH_DECODE) return;
    case (cur_enc)
      ENC_LATIN1: begin
        add_result({24'h0, b}, ST_CHAR);
      end
      ENC_UCS4BE, ENC_UCS4LE: begin
        unit_acc = {unit_acc[23:0], b};
        unit_cnt++;
        if (unit_cnt >= 4) begin
          w = unit_acc;
          if (cur_enc == ENC_UCS4LE) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
          add_result(w, ST_CHAR);
          unit_acc = '0;
          unit_cnt = 0;
        end
      end
      ENC_UTF16BE, ENC_UTF16LE: begin
        unit_acc = {16'h0, unit_acc[7:0], b};
        unit_cnt++;
        if (unit_cnt >= 2) begin
          u = unit_acc[15:0];
          if (cur_enc == ENC_UTF16LE) u = {u[7:0], u[15:8]};
          unit_acc = '0;
          unit_cnt = 0;
          if (sur_pend) begin
            if (u >= 16'hDC00 && u <= 16'hDFFF) begin
              add_result((({16'h0, hi_sur} - 32'hD800) << 10)
                         + ({16'h0, u} - 32'hDC00) + 32'h10000, ST_CHAR);
              sur_pend = 1'b0;
              hi_sur   = '0;
            end else begin
              add_result(32'h0, ST_BADSUR);
              dec_phase = PH_HALT;
            end
          end else if (u >= 16'hD800 && u <= 16'hDBFF) begin
            hi_sur   = u;
            sur_pend = 1'b1;
          end else begin
            add_result({16'h0, u}, ST_CHAR);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // commit to an encoding, then replay the buffered bytes past the mark or report it unsupported
  function automatic void pick_enc(enc_t e, int skip);
    cur_enc = e;
    if (e == ENC_UTF8 || e == ENC_EBCDIC) begin
      dec_phase = PH_HALT;
      add_result(32'h0, ST_UNSUP);
      return;
    end
    dec_phase = PH_DECODE;
    for (int i = skip; i < sn_cnt; i++) decode_byte(sn_buf[i]);
  endfunction

  function automatic void sniff_byte(logic [7:0] b, logic eos);
    logic [31:0] w;
    if (sn_cnt < 4) begin
      sn_buf[sn_cnt] = b;
      sn_cnt++;
    end
    if (sn_cnt == 2 && {sn_buf[0], sn_buf[1]} == MARK_UTF16BE) begin
      pick_enc(ENC_UTF16BE, 2);
    end else if (sn_cnt == 3 && {sn_buf[0], sn_buf[1], sn_buf[2]} == MARK_UTF8) begin
      pick_enc(ENC_UTF8, 3);
    end else if (sn_cnt == 4) begin
      w = {sn_buf[0], sn_buf[1], sn_buf[2], sn_buf[3]};
      if (w == MARK_UCS4LE)                pick_enc(ENC_UCS4LE, 4);
      else if (w[31:16] == MARK_UTF16LE)   pick_enc(ENC_UTF16LE, 2);
      else if (w == MARK_UCS4BE)           pick_enc(ENC_UCS4BE, 4);
      else if (w == DECL_UTF16BE)          pick_enc(ENC_UTF16BE, 0);
      else if (w == DECL_UTF16LE)          pick_enc(ENC_UTF16LE, 0);
      else if (w == DECL_UTF8)             pick_enc(ENC_UTF8, 4);
      else if (w == DECL_EBCDIC)           pick_enc(ENC_EBCDIC, 4);
      else                                 pick_enc(ENC_LATIN1, 0);
    end else if (eos) begin
      if (sn_cnt >= 2 && {sn_buf[0], sn_buf[1]} == MARK_UTF16LE) pick_enc(ENC_UTF16LE, 2);
      else pick_enc(ENC_LATIN1, 0);
    end
  endfunction

  // results one accepted byte causes, left in step_res
  function automatic void decode_step(logic [7:0] b, logic eos);
    step_res.delete();
    if (dec_phase == PH_SNIFF) sniff_byte(b, eos);
    else if (dec_phase == PH_DECODE) decode_byte(b);
    if (eos) begin
      add_result(32'h0, ST_END);
      reset_model();
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].run_last = 1'b1;
  endfunction

  function automatic bit calm_now();
    return items_sent >= CALM_FROM && items_sent < CALM_TO;
  endfunction

  // offer one byte, hold it until accepted, then record what it must produce
  task automatic send_byte(logic [7:0] b, logic eos, logic typed, result_t typed_res);
    while (!calm_now() && $urandom_range(99) < 22) begin
      bytes_if.valid <= 1'b0;
      @(negedge clk);
    end
    bytes_if.valid       <= 1'b1;
    bytes_if.data_byte   <= b;
    bytes_if.stream_last <= eos;
    do @(posedge clk); while (!bytes_if.ready);
    decode_step(b, eos);
    if (typed) expected_q.push_back(typed_res);
    else foreach (step_res[i]) expected_q.push_back(step_res[i]);
    items_sent++;
    if (eos) streams_sent++;
    @(negedge clk);
  endtask

  function automatic void put_byte(logic [7:0] b);
    byte_item_t it;
    it.data = b;
    it.eos  = 1'b0;
    stim_q.push_back(it);
  endfunction

  function automatic void put_unit16(logic [15:0] u, bit le);
    if (le) begin
      put_byte(u[7:0]);
      put_byte(u[15:8]);
    end else begin
      put_byte(u[15:8]);
      put_byte(u[7:0]);
    end
  endfunction

  function automatic void put_word32(logic [31:0] w);
    put_byte(w[31:24]);
    put_byte(w[23:16]);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endfunction

  // mostly legal UTF-16 text with pairs, plus lone and broken surrogates
  function automatic void put_body16(bit le);
    int r;
    int n;
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        put_unit16($urandom_range(1) ? 16'hFFFF : 16'h0000, le);
      end else if (r < 50) begin
        put_unit16(16'($urandom_range(16'hFFFF)), le);
      end else if (r < 80) begin
        put_unit16(16'hD800 + 16'($urandom_range(16'h3FF)), le);
        put_unit16(16'hDC00 + 16'($urandom_range(16'h3FF)), le);
      end else if (r < 88) begin
        put_unit16(16'hDC00 + 16'($urandom_range(16'h3FF)), le);
      end else if (r < 94) begin
        put_unit16(16'hD800 + 16'($urandom_range(16'h3FF)), le);
      end else begin
        put_unit16(16'hD800 + 16'($urandom_range(16'h3FF)), le);
        put_unit16(16'($urandom_range(16'hD7FF)), le);
      end
    end
    if ($urandom_range(3) == 0) put_byte(8'($urandom_range(255)));
  endfunction

  function automatic void put_body32(bit le);
    logic [31:0] w;
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: w = 32'h0;
        1: w = 32'hFFFFFFFF;
        2: w = $urandom();
        default: w = 32'($urandom_range(32'h10FFFF));
      endcase
      put_word32(le ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w);
    end
    for (int i = $urandom_range(0, 3); i > 0; i--) put_byte(8'($urandom_range(255)));
  endfunction

  function automatic void put_tail(int hi);
    for (int i = $urandom_range(0, hi); i > 0; i--) put_byte(8'($urandom_range(255)));
  endfunction

  function automatic void build_stream(stream_kind_e k);
    stim_q.delete();
    case (k)
      SK_BOM16BE: begin put_unit16(MARK_UTF16BE, 0); put_body16(0); end
      SK_BOM16LE: begin put_unit16(MARK_UTF16BE, 1); put_body16(1); end
      SK_BOM32LE: begin put_word32(MARK_UCS4LE); put_body32(1); end
      SK_BOM32BE: begin put_word32(MARK_UCS4BE); put_body32(0); end
      SK_XML16BE: begin put_word32(DECL_UTF16BE); put_body16(0); end
      SK_XML16LE: begin put_word32(DECL_UTF16LE); put_body16(1); end
      SK_XML8:    begin put_word32(DECL_UTF8); put_tail(3); end
      SK_BOM8: begin
        put_byte(MARK_UTF8[23:16]);
        put_byte(MARK_UTF8[15:8]);
        put_byte(MARK_UTF8[7:0]);
        put_tail(3);
      end
      SK_EBCDIC:  begin put_word32(DECL_EBCDIC); put_tail(3); end
      SK_LATIN1: begin
        for (int i = $urandom_range(1, 8); i > 0; i--) put_byte(8'($urandom_range(255)));
      end
      default: begin
        // short or garbage streams, some that end right after an FF FE mark
        if ($urandom_range(1)) begin
          put_unit16(MARK_UTF16LE, 0);
          put_tail(1);
        end else begin
          for (int i = $urandom_range(1, 5); i > 0; i--) put_byte(8'($urandom_range(255)));
        end
      end
    endcase
    stim_q[stim_q.size() - 1].eos = 1'b1;
  endfunction

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left    = 0;
    hold_done    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (calm_now()) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.code_point = res_if.code_point;
      got.status     = status_t'(res_if.status);
      got.enc        = enc_t'(res_if.detected_encoding);
      got.run_last   = res_if.run_last;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 30)
          $display("%0t: unexpected result cp=%h status=%0d enc=%0d last=%b", $time,
                   got.code_point, got.status, got.enc, got.run_last);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 30)
            $display("%0t: mismatch expected cp=%h status=%0d enc=%0d last=%b, got cp=%h status=%0d enc=%0d last=%b",
                     $time, want.code_point, want.status, want.enc, want.run_last,
                     got.code_point, got.status, got.enc, got.run_last);
        end
      end
    end
  end

  initial begin
    result_t     typed_res;
    int          rand_sent;
    int          stream_idx;
    byte_item_t  it;
    stream_kind_e k;
    items_sent           = 0;
    streams_sent         = 0;
    results_seen         = 0;
    mismatches           = 0;
    rand_sent            = 0;
    stream_idx           = 0;
    rst                  = 1'b1;
    bytes_if.valid       = 1'b0;
    bytes_if.data_byte   = 8'h00;
    bytes_if.stream_last = 1'b0;
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIR_TAB[i]) begin
      typed_res.code_point = DIR_TAB[i].cp;
      typed_res.status     = DIR_TAB[i].st;
      typed_res.enc        = DIR_TAB[i].enc;
      typed_res.run_last   = 1'b1;
      send_byte(DIR_TAB[i].data, DIR_TAB[i].eos, DIR_TAB[i].typed, typed_res);
    end

    // walk every stream kind once, then pick kinds at random
    while (rand_sent < RAND_ITEMS) begin
      if (stream_idx <= SK_NOISE) k = stream_kind_e'(stream_idx);
      else k = stream_kind_e'($urandom_range(SK_NOISE));
      build_stream(k);
      if (stream_idx == PAUSE_AT) begin
        bytes_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      foreach (stim_q[i]) begin
        it = stim_q[i];
        send_byte(it.data, it.eos, 1'b0, typed_res);
        rand_sent++;
      end
      stream_idx++;
    end
    bytes_if.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d bytes in %0d streams covering all marks, declarations and fallbacks;",
             items_sent, streams_sent);
    $display("compared %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/udec_pkg.sv
rtl/udec_byte_if.sv
rtl/udec_result_if.sv
rtl/udec_front.sv
rtl/udec_queue.sv
rtl/udec_back.sv
rtl/unicode_stream_decoder.sv
rtl/udec_checker.sv
tb/tb_unicode_stream_decoder.sv
